// ===== sv/pac_pkg.sv =====
`timescale 1ns / 1ps

package pac_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;                  // measured / target
  localparam int DT_W      = 18;                  // interval, Q2.16
  localparam int GAIN_W    = 24;                  // gains, Q8.16
  localparam int DRIVE_W   = 18;                  // drive, Q2.16
  localparam int ERR_W     = VAL_W + 1;           // error, Q17.16
  localparam int DIFF_W    = ERR_W + 1;           // error change
  localparam int ACC_W     = 48;                  // integral and derivative range
  localparam int QUO_W     = ERR_W + FRAC_BITS;   // derivative quotient
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int MUL_A_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + GAIN_W;
  localparam int HALF_W    = ACC_W / 2;           // magnitude split for gain products
  localparam int HI_SH     = HALF_W - FRAC_BITS;
  localparam int TERM_EXP  = 52;                  // product terms saturate at 2^52
  localparam int TERM_W    = TERM_EXP + 2;
  localparam int SUM_W     = TERM_W + 2;

  localparam logic [ACC_W-2:0]    ACC_MAX_MAG  = '1;
  localparam logic [MUL_P_W-1:0]  HI_LIM       = MUL_P_W'(1) << (TERM_EXP - HI_SH);
  localparam logic [MUL_P_W-1:0]  TERM_LIM     = MUL_P_W'(1) << TERM_EXP;
  localparam logic signed [SUM_W-1:0] ONE_SUM  = SUM_W'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIPOLAR = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd9830;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd2621;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd19661;

  // Shared multiplier operand selection
  typedef enum logic [1:0] {
    MUL_INT = 2'd0,   // |error| * interval
    MUL_LO  = 2'd1,   // low half of term magnitude * gain
    MUL_HI  = 2'd2    // high half of term magnitude * gain
  } mul_sel_e;

  // Which gain term is being formed
  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     calc_err;
    logic     div_start;
    logic     mul_en;
    mul_sel_e mul_sel;
    term_e    term;
    logic     lo_save;
    logic     int_upd;
    logic     term_add;
    logic     finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic active;
    logic div_done;
  } status_t;

endpackage

// ===== sv/pid_axis_controller.sv =====
`timescale 1ns / 1ps
// Items are handled one at a time. An active item passes through error, divide,
// integral and the three gain terms; the 49-step restoring divider is most of it.
// A standby item skips the arithmetic. A new item is accepted only when idle.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_ni low, async): stored error and integral cleared, gains and mode
// return to their defaults, no result pending.

module pid_axis_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: measured[31:0], target[63:32], interval[81:64], zero pad [87:82]
  input  logic [87:0]                    s_axis_tdata_i,
  // tuser: active[0]
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: drive[17:0], zero pad [23:18]
  output logic [23:0]                    m_axis_tdata_o,
  // tuser: clamped[0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pac_pkg::GAIN_W-1:0]     cfg_data_i
);

  // Configuration registers
  logic [pac_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic                       unipolar_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= pac_pkg::GAIN_P_RST;
      gain_i_q   <= pac_pkg::GAIN_I_RST;
      gain_d_q   <= pac_pkg::GAIN_D_RST;
      unipolar_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pac_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data_i;
        pac_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data_i;
        pac_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data_i;
        pac_pkg::CFG_UNIPOLAR: unipolar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Result valid flag
  logic out_valid_q;
  logic out_free;
  pac_pkg::cmd_t    cmd;
  pac_pkg::status_t status;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  pac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  logic signed [pac_pkg::DRIVE_W-1:0] drive;
  logic                               clamped;

  pac_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .measured_i (s_axis_tdata_i[31:0]),
    .target_i   (s_axis_tdata_i[63:32]),
    .interval_i (s_axis_tdata_i[81:64]),
    .active_i   (s_axis_tuser_i),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .unipolar_i (unipolar_q),
    .drive_o    (drive),
    .clamped_o  (clamped)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24 - pac_pkg::DRIVE_W){1'b0}}, drive};
  assign m_axis_tuser_o  = clamped;

endmodule

// ===== sv/pac_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module pac_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pac_pkg::QUO_W-1:0]     dividend_i,
  input  logic [pac_pkg::DT_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic [pac_pkg::QUO_W-1:0]     quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [pac_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [pac_pkg::QUO_W-1:0]         quo_q, quo_d;
  logic [pac_pkg::DT_W-1:0]          rem_q, rem_d;
  logic [pac_pkg::DT_W-1:0]          dsr_q, dsr_d;
  logic [pac_pkg::DT_W:0]            rem_sh;
  logic                              fits;

  // Trial subtract of the shifted remainder
  assign rem_sh = {rem_q, quo_q[pac_pkg::QUO_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? pac_pkg::DT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[pac_pkg::DT_W-1:0];
      quo_d = {quo_q[pac_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pac_pkg::DIV_CNT_W'(pac_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/pac_dpath.sv =====
`timescale 1ns / 1ps

// PID datapath: error, divider, shared multiplier, integral, sum and clamp
module pac_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pac_pkg::cmd_t                       cmd_i,
  output pac_pkg::status_t                    status_o,
  input  logic signed [pac_pkg::VAL_W-1:0]    measured_i,
  input  logic signed [pac_pkg::VAL_W-1:0]    target_i,
  input  logic [pac_pkg::DT_W-1:0]            interval_i,
  input  logic                                active_i,
  input  logic [pac_pkg::GAIN_W-1:0]          gain_p_i,
  input  logic [pac_pkg::GAIN_W-1:0]          gain_i_i,
  input  logic [pac_pkg::GAIN_W-1:0]          gain_d_i,
  input  logic                                unipolar_i,
  output logic signed [pac_pkg::DRIVE_W-1:0]  drive_o,
  output logic                                clamped_o
);

  // Item registers
  logic signed [pac_pkg::VAL_W-1:0]   meas_q, targ_q;
  logic [pac_pkg::DT_W-1:0]           dt_q;
  logic                               active_q;

  // Per-item working registers
  logic [pac_pkg::VAL_W-1:0]          err_mag_q;
  logic                               err_neg_q;
  logic signed [pac_pkg::ERR_W-1:0]   err_q;
  logic [pac_pkg::ERR_W-1:0]          diff_mag_q;
  logic                               diff_neg_q;
  logic [pac_pkg::MUL_P_W-1:0]        prod_q;
  logic [pac_pkg::MUL_P_W-1:0]        lo_q;
  logic signed [pac_pkg::SUM_W-1:0]   sum_q;
  logic                               sat_q;
  logic signed [pac_pkg::DRIVE_W-1:0] drive_q;
  logic                               clamped_q;

  // State carried between items
  logic signed [pac_pkg::ERR_W-1:0]   prev_err_q;
  logic signed [pac_pkg::ACC_W-1:0]   integ_q;

  // Error and change of error
  logic signed [pac_pkg::ERR_W-1:0]   err_d;
  logic signed [pac_pkg::DIFF_W-1:0]  diff_d;
  logic signed [pac_pkg::ERR_W-1:0]   err_abs;
  logic signed [pac_pkg::DIFF_W-1:0]  diff_abs;

  assign err_d    = {targ_q[pac_pkg::VAL_W-1], targ_q} - {meas_q[pac_pkg::VAL_W-1], meas_q};
  assign diff_d   = {err_d[pac_pkg::ERR_W-1], err_d}
                  - {prev_err_q[pac_pkg::ERR_W-1], prev_err_q};
  assign err_abs  = err_d[pac_pkg::ERR_W-1] ? -err_d : err_d;
  assign diff_abs = diff_d[pac_pkg::DIFF_W-1] ? -diff_d : diff_d;

  // Derivative magnitude from the divider, saturated, zero for zero interval
  logic                               div_done;
  logic [pac_pkg::QUO_W-1:0]          quotient;
  logic [pac_pkg::ACC_W-2:0]          deriv_mag;

  pac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({diff_mag_q, {pac_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (dt_q == '0) begin
      deriv_mag = '0;
    end else if (quotient[pac_pkg::QUO_W-1:pac_pkg::ACC_W-1] != '0) begin
      deriv_mag = pac_pkg::ACC_MAX_MAG;
    end else begin
      deriv_mag = quotient[pac_pkg::ACC_W-2:0];
    end
  end

  // Magnitude, sign and gain of the selected term
  logic [pac_pkg::ACC_W-1:0]          integ_mag;
  logic [pac_pkg::ACC_W-1:0]          tmag;
  logic                               tneg;
  logic [pac_pkg::GAIN_W-1:0]         tgain;

  assign integ_mag = integ_q[pac_pkg::ACC_W-1] ? pac_pkg::ACC_W'(-integ_q)
                                               : pac_pkg::ACC_W'(integ_q);

  always_comb begin
    case (cmd_i.term)
      pac_pkg::TERM_P: begin
        tmag  = pac_pkg::ACC_W'(err_mag_q);
        tneg  = err_neg_q;
        tgain = gain_p_i;
      end
      pac_pkg::TERM_I: begin
        tmag  = integ_mag;
        tneg  = integ_q[pac_pkg::ACC_W-1];
        tgain = gain_i_i;
      end
      pac_pkg::TERM_D: begin
        tmag  = {1'b0, deriv_mag};
        tneg  = diff_neg_q;
        tgain = gain_d_i;
      end
      default: begin
        tmag  = '0;
        tneg  = 1'b0;
        tgain = '0;
      end
    endcase
  end

  // Shared multiplier operands
  logic [pac_pkg::MUL_A_W-1:0]        mul_a;
  logic [pac_pkg::GAIN_W-1:0]         mul_b;
  logic [pac_pkg::MUL_P_W-1:0]        mul_p;

  always_comb begin
    case (cmd_i.mul_sel)
      pac_pkg::MUL_INT: begin
        mul_a = err_mag_q;
        mul_b = pac_pkg::GAIN_W'(dt_q);
      end
      pac_pkg::MUL_LO: begin
        mul_a = pac_pkg::MUL_A_W'(tmag[pac_pkg::HALF_W-1:0]);
        mul_b = tgain;
      end
      pac_pkg::MUL_HI: begin
        mul_a = pac_pkg::MUL_A_W'(tmag[pac_pkg::ACC_W-1:pac_pkg::HALF_W]);
        mul_b = tgain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update with saturation
  localparam int ISUM_W = pac_pkg::ACC_W + 2;
  logic [pac_pkg::MUL_P_W-pac_pkg::FRAC_BITS-1:0] pm;
  logic signed [ISUM_W-1:0]           pm_s;
  logic signed [ISUM_W-1:0]           isum;
  logic signed [pac_pkg::ACC_W-1:0]   integ_sat;
  logic                               integ_ovf;

  assign pm   = prod_q[pac_pkg::MUL_P_W-1:pac_pkg::FRAC_BITS];
  assign pm_s = err_neg_q ? -ISUM_W'(pm) : ISUM_W'(pm);
  assign isum = ISUM_W'(integ_q) + pm_s;

  always_comb begin
    integ_ovf = 1'b0;
    integ_sat = isum[pac_pkg::ACC_W-1:0];
    if (isum[ISUM_W-1:pac_pkg::ACC_W-1] != '0 && isum[ISUM_W-1:pac_pkg::ACC_W-1] != '1) begin
      integ_ovf = 1'b1;
      integ_sat = isum[ISUM_W-1] ? {1'b1, {(pac_pkg::ACC_W-1){1'b0}}}
                                 : {1'b0, pac_pkg::ACC_MAX_MAG};
    end
  end

  // Gain term from the high and low partial products
  logic [pac_pkg::MUL_P_W-1:0]        term_r;
  logic [pac_pkg::MUL_P_W-1:0]        term_mag;
  logic signed [pac_pkg::SUM_W-1:0]   term_s;

  assign term_r = (prod_q << pac_pkg::HI_SH) + (lo_q >> pac_pkg::FRAC_BITS);

  always_comb begin
    if (prod_q >= pac_pkg::HI_LIM || term_r > pac_pkg::TERM_LIM) begin
      term_mag = pac_pkg::TERM_LIM;
    end else begin
      term_mag = term_r;
    end
    term_s = tneg ? -pac_pkg::SUM_W'(term_mag) : pac_pkg::SUM_W'(term_mag);
  end

  // Output clamp
  logic signed [pac_pkg::SUM_W-1:0]   lower;
  logic signed [pac_pkg::SUM_W-1:0]   sum_clamp;
  logic                               out_sat;

  assign lower = unipolar_i ? '0 : -pac_pkg::ONE_SUM;

  always_comb begin
    out_sat   = 1'b0;
    sum_clamp = sum_q;
    if (sum_q > pac_pkg::ONE_SUM) begin
      sum_clamp = pac_pkg::ONE_SUM;
      out_sat   = 1'b1;
    end else if (sum_q < lower) begin
      sum_clamp = lower;
      out_sat   = 1'b1;
    end
  end

  // Control-side registers and carried state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      prev_err_q <= '0;
      integ_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        active_q <= active_i;
      end
      if (cmd_i.int_upd) begin
        integ_q <= integ_sat;
      end
      if (cmd_i.finish) begin
        if (active_q) begin
          prev_err_q <= err_q;
        end else begin
          prev_err_q <= '0;
          integ_q    <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      meas_q <= measured_i;
      targ_q <= target_i;
      dt_q   <= interval_i;
    end
    if (cmd_i.calc_err) begin
      err_q      <= err_d;
      err_mag_q  <= err_abs[pac_pkg::VAL_W-1:0];
      err_neg_q  <= err_d[pac_pkg::ERR_W-1];
      diff_mag_q <= diff_abs[pac_pkg::ERR_W-1:0];
      diff_neg_q <= diff_d[pac_pkg::DIFF_W-1];
      sum_q      <= '0;
      sat_q      <= 1'b0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.lo_save) begin
      lo_q <= prod_q;
    end
    if (cmd_i.int_upd && integ_ovf) begin
      sat_q <= 1'b1;
    end
    if (cmd_i.term_add) begin
      sum_q <= sum_q + term_s;
    end
    if (cmd_i.finish) begin
      if (active_q) begin
        drive_q   <= sum_clamp[pac_pkg::DRIVE_W-1:0];
        clamped_q <= sat_q | out_sat;
      end else begin
        drive_q   <= '0;
        clamped_q <= 1'b0;
      end
    end
  end

  assign status_o.active   = active_q;
  assign status_o.div_done = div_done;
  assign drive_o           = drive_q;
  assign clamped_o         = clamped_q;

endmodule

// ===== sv/pac_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer for one item: error, divide, integral, three gain terms, clamp
module pac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  input  pac_pkg::status_t   status_i,
  output pac_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_MULI = 4'd4;
  localparam logic [3:0] S_INTG = 4'd5;
  localparam logic [3:0] S_LO   = 4'd6;
  localparam logic [3:0] S_HI   = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]     state_q, state_d;
  pac_pkg::term_e term_q, term_d;

  always_comb begin
    state_d       = state_q;
    term_d        = term_q;
    cmd_o         = '0;
    cmd_o.mul_sel = pac_pkg::MUL_INT;
    cmd_o.term    = term_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ERR;
        end
      end
      S_ERR: begin
        // standby items skip all arithmetic
        if (status_i.active) begin
          cmd_o.calc_err = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_MULI;
        end
      end
      S_MULI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pac_pkg::MUL_INT;
        state_d       = S_INTG;
      end
      S_INTG: begin
        cmd_o.int_upd = 1'b1;
        term_d        = pac_pkg::TERM_P;
        state_d       = S_LO;
      end
      S_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pac_pkg::MUL_LO;
        state_d       = S_HI;
      end
      S_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pac_pkg::MUL_HI;
        cmd_o.lo_save = 1'b1;
        state_d       = S_ADD;
      end
      S_ADD: begin
        cmd_o.term_add = 1'b1;
        unique case (term_q)
          pac_pkg::TERM_P: begin
            term_d  = pac_pkg::TERM_I;
            state_d = S_LO;
          end
          pac_pkg::TERM_I: begin
            term_d  = pac_pkg::TERM_D;
            state_d = S_LO;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        // result register must be free or draining this cycle
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      term_q  <= pac_pkg::TERM_P;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

endmodule
